// ----- hw/rtl/tpc_pkg.sv -----
// Shared types and constants for the triangle plane clipper.
package tpc_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int T_BITS = 30;
  localparam int COORD_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_OFFSET = 2'd3;

  // Divider request and reply between the sequencer and the shared divider.
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [30:0] quot;
  } div_rsp_t;

endpackage

// ----- hw/rtl/tpc_divider.sv -----
// Restoring radix-2 divider that forms floor(num * 2^30 / den), one bit per cycle.
module tpc_divider (
  input  logic              clk,
  input  logic              rst,
  input  tpc_pkg::div_req_t req,
  output tpc_pkg::div_rsp_t rsp
);

  logic [32:0] rem;
  logic [62:0] dividend;
  logic [31:0] den;
  logic [30:0] quot;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [33:0] trial;

  // Shifted-in remainder bit and trial subtraction.
  assign trial = {rem, dividend[62]} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy     <= 1'b1;
        rem      <= '0;
        dividend <= {1'b0, req.num, 30'd0};
        den      <= req.den;
        cnt      <= 6'd63;
      end else if (busy) begin
        dividend <= {dividend[61:0], 1'b0};
        if (!trial[33]) begin
          rem  <= trial[32:0];
          quot <= {quot[29:0], 1'b1};
        end else begin
          rem  <= {rem[31:0], dividend[62]};
          quot <= {quot[29:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

// ----- hw/rtl/triangle_plane_clipper_unit.sv -----
// Triangle clipper against one plane: vertex store, distance, divider and output sequencer.
//
// Use: vertices arrive on the s_axis channel, one per transaction; every third closes a
// triangle. Clipped vertices leave on m_axis with tuser = end_of_triangle and tlast set
// on the final vertex produced for the input triangle. The plane is written on the cfg
// channel (index 0..2 normal x/y/z, 3 plane offset) while no triangle is in progress.
// The first two vertices of a triangle are stored in the load state. The third starts
// the clip: three signed distances are formed on one shared 33x33 multiplier (three
// products and one compare per vertex, then a classify step). Each crossing then takes
// two setup steps, normalizing shifts and a start, a divide on the one-bit-per-cycle
// divider and six interpolations on the same multiplier (a multiply and an accumulate
// step each). Output vertices are held in a single output register; while the receiver
// stalls the sequencer waits and nothing is lost. s_axis tready is low from the third
// vertex until the last result transaction completes, or for a dropped triangle until
// it has been classified.
// Reset clears the vertex count, sequencer and output valid, and restores the plane
// to normal (0,0,1) with offset zero; the vertex store itself is not cleared.
module triangle_plane_clipper_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v, tex_w
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [191:0] m_axis_tdata,   // out_x, out_y, out_z, out_u, out_v, out_w
  output logic         m_axis_tuser,   // end_of_triangle
  output logic         m_axis_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  typedef enum logic [3:0] {
    S_LOAD, S_DMUL, S_DACC, S_CLASS, S_PICK, S_DIVGO, S_SCALE, S_DIVWAIT,
    S_IMUL, S_IACC, S_EMIT, S_WAIT
  } state_t;

  state_t state;
  logic [1:0]  vcount;
  logic signed [31:0] vstore [3][6];
  logic signed [31:0] nx, ny, nz;
  logic signed [63:0] poff;
  logic signed [65:0] dacc;
  logic signed [65:0] vdist [3];
  logic [2:0]  in_mask;
  logic [1:0]  vi;
  logic [2:0]  comp;
  logic signed [31:0] xv [2][6];
  logic        xsel;
  logic [2:0]  step;          // emission step
  logic [1:0]  ia, ib, oa, ob;
  logic [1:0]  pin, pout;
  logic [30:0] tval;
  logic signed [65:0] mprod;
  logic signed [32:0] ma, mb;
  logic signed [32:0] diff;
  logic [1:0]  ninside;
  logic [1:0]  ev;
  logic        ex, eend, elast;
  logic        emit_fire;
  tpc_pkg::div_req_t dreq;
  tpc_pkg::div_rsp_t drsp;
  logic [64:0] sa, ss;
  logic signed [65:0] dsum;

  tpc_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign s_axis_tready = (state == S_LOAD);
  assign cfg_ready = (state == S_LOAD) && (vcount == 2'd0) && !m_axis_tvalid;
  assign ninside = 2'(in_mask[0]) + 2'(in_mask[1]) + 2'(in_mask[2]);
  assign emit_fire = (state == S_EMIT) && (!m_axis_tvalid || m_axis_tready);

  // Single shared multiplier: distance terms, then interpolation.
  always_comb begin
    if (state == S_IMUL) begin
      ma = diff;
      mb = $signed({2'b00, tval});
    end else begin
      case (comp)
        3'd1: ma = 33'(ny);
        3'd2: ma = 33'(nz);
        default: ma = 33'(nx);
      endcase
      mb = 33'(vstore[vi][comp]);
    end
  end
  assign mprod = ma * mb;
  assign diff = 33'(vstore[pout][comp]) - 33'(vstore[pin][comp]);

  // Crossing operands: a = D_in, b = -D_out on quarter distances, scaled until the
  // sum fits 32 bits.
  assign dsum = vdist[pin] - vdist[pout];

  // Emission schedule by case.
  always_comb begin
    ev = 2'd0; ex = 1'b0; eend = 1'b0; elast = 1'b0;
    if (ninside == 2'd3) begin
      ev = step[1:0]; eend = (step == 3'd2); elast = eend;
    end else if (ninside == 2'd1) begin
      case (step)
        3'd0: ev = ia;
        3'd1: ex = 1'b1;
        default: begin ex = 1'b1; eend = 1'b1; elast = 1'b1; end
      endcase
    end else begin
      case (step)
        3'd0: ev = ia;
        3'd1: ev = ib;
        3'd2: begin ex = 1'b1; eend = 1'b1; end
        3'd3: ev = ib;
        3'd4: ex = 1'b1;
        default: begin ex = 1'b1; eend = 1'b1; elast = 1'b1; end
      endcase
    end
  end

  // Which crossing a given emission step uses.
  logic xidx;
  assign xidx = (ninside == 2'd1) ? (step == 3'd2) : (step == 3'd5);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      vcount <= '0;
      m_axis_tvalid <= 1'b0;
      nx <= '0; ny <= '0; nz <= 32'sd65536; poff <= '0;
      dreq.start <= 1'b0;
    end else begin
      dreq.start <= (state == S_SCALE) && (ss[64:32] == '0);
      if (emit_fire) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tpc_pkg::REG_NORMAL_X: nx <= cfg_data[31:0];
          tpc_pkg::REG_NORMAL_Y: ny <= cfg_data[31:0];
          tpc_pkg::REG_NORMAL_Z: nz <= cfg_data[31:0];
          tpc_pkg::REG_PLANE_OFFSET: poff <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_LOAD: if (s_axis_tvalid) begin
          for (int j = 0; j < 6; j++) vstore[vcount][j] <= s_axis_tdata[32*j +: 32];
          if (vcount == 2'd2) begin
            vcount <= '0; state <= S_DMUL; vi <= '0; comp <= '0;
            dacc <= -66'(poff);
          end else vcount <= vcount + 2'd1;
        end
        S_DMUL: begin
          dacc <= dacc + mprod;
          if (comp == 3'd2) state <= S_DACC;
          else comp <= comp + 3'd1;
        end
        S_DACC: begin
          // Keep the quarter distance; its sign matches the full distance.
          vdist[vi] <= dacc >>> 2;
          in_mask[vi] <= !dacc[65];
          comp <= '0;
          dacc <= -66'(poff);
          if (vi == 2'd2) state <= S_CLASS;
          else begin
            vi <= vi + 2'd1;
            state <= S_DMUL;
          end
        end
        S_CLASS: begin
          // Order inside and outside vertices by arrival.
          ia <= in_mask[0] ? 2'd0 : (in_mask[1] ? 2'd1 : 2'd2);
          ib <= (in_mask[0] && in_mask[1]) ? 2'd1 : 2'd2;
          oa <= !in_mask[0] ? 2'd0 : (!in_mask[1] ? 2'd1 : 2'd2);
          ob <= (!in_mask[0] && !in_mask[1]) ? 2'd1 : 2'd2;
          xsel <= 1'b0; step <= '0;
          if (ninside == 2'd0) state <= S_LOAD;
          else if (ninside == 2'd3) state <= S_EMIT;
          else state <= S_PICK;
        end
        S_PICK: begin
          pin  <= xsel ? ((ninside == 2'd1) ? ia : ib) : ia;
          pout <= xsel ? ((ninside == 2'd1) ? ob : oa) : oa;
          state <= S_DIVGO;
        end
        S_DIVGO: begin
          sa <= vdist[pin][64:0];
          ss <= dsum[64:0];
          state <= S_SCALE;
        end
        S_SCALE: begin
          if (ss[64:32] != '0) begin
            sa <= sa >> 1; ss <= ss >> 1;
          end else begin
            dreq.num <= sa[31:0];
            dreq.den <= (ss[31:0] == '0) ? 32'd1 : ss[31:0];
            state <= S_DIVWAIT;
          end
        end
        S_DIVWAIT: if (drsp.done) begin
          tval <= drsp.quot; comp <= '0; state <= S_IMUL;
        end
        S_IMUL: begin
          dacc <= mprod + (66'sd1 <<< (tpc_pkg::T_BITS - 1));
          state <= S_IACC;
        end
        S_IACC: begin
          xv[xsel][comp] <= vstore[pin][comp] + 32'(dacc >>> tpc_pkg::T_BITS);
          if (comp == 3'd5) begin
            if (xsel) state <= S_EMIT;
            else begin xsel <= 1'b1; state <= S_PICK; end
          end else begin
            comp <= comp + 3'd1; state <= S_IMUL;
          end
        end
        S_EMIT: if (emit_fire) begin
          for (int j = 0; j < 6; j++)
            m_axis_tdata[32*j +: 32] <= ex ? xv[xidx][j] : vstore[ev][j];
          m_axis_tuser <= eend;
          m_axis_tlast <= elast;
          step <= step + 3'd1;
          if (elast) state <= S_WAIT;
        end
        S_WAIT: if (!m_axis_tvalid || m_axis_tready) state <= S_LOAD;
        default: state <= S_LOAD;
      endcase
    end
  end

  a_tready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> (state == S_LOAD)) else $error("tready outside load");
  a_div_ok: assert property (@(posedge clk) disable iff (rst)
    dreq.start |=> drsp.busy) else $error("divider did not start");
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> !m_axis_tvalid) else $error("cfg while output pending");

endmodule
